// ===== hdl/badc_pkg.sv =====
// ----------------------------------------------------------------------------
// badc_pkg: shared types and constants of the block average delta codec
// Block size, item payload structs and the block position struct.
// ----------------------------------------------------------------------------
package badc_pkg;

	localparam int BLOCK_DIM = 8;
	localparam int IDX_W     = (BLOCK_DIM > 2) ? $clog2(BLOCK_DIM) : 1;
	localparam int DATA_W    = 32;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BLOCK_DIM - 1);

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sample;
		logic signed [DATA_W-1:0] first_value;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] block_first;
		logic                     block_end;
	} out_item_t;

	typedef struct packed {
		idx_t row;
		idx_t col;
	} pos_t;

endpackage

// ===== hdl/block_average_delta_codec_top.sv =====
// ----------------------------------------------------------------------------
// block_average_delta_codec_top: block average delta codec
// Encodes a raster block of Q16.16 samples into residuals or decodes back.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the result side stalls; the single
// stage after the input register computes each item from the left value and
// the row store read at accept. Reset clears position, left value, direction
// and the valid flags; the row store is not cleared, since the first row of a
// block never reads it.
module block_average_delta_codec_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  badc_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output badc_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import badc_pkg::*;

	logic      direction_q;
	logic      valid_s1;
	in_item_t  item_s1;
	pos_t      pos_s1;
	word_t     left_q;
	out_item_t result_q;
	logic      result_valid_q;

	logic      adv_s1;
	logic      accept;
	pos_t      pos_in;
	word_t     upper;
	word_t     sample;
	out_item_t result_d;

	assign adv_s1     = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	badc_pos u_pos (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(accept),
		.pos    (pos_in)
	);

	badc_row_mem u_row_mem (
		.clk    (clk),
		.wr_en  (adv_s1),
		.wr_addr(pos_s1.col),
		.wr_data(sample),
		.rd_en  (accept),
		.rd_addr(pos_in.col),
		.rd_data(upper)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
			pos_s1  <= pos_in;
		end
	end

	badc_dp u_dp (
		.direction(direction_q),
		.pos      (pos_s1),
		.item     (item_s1),
		.left     (left_q),
		.upper    (upper),
		.result   (result_d),
		.sample   (sample)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (adv_s1) begin
			left_q <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef ASSERT_OFF
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(pos_s1))
		else $error("stage item dropped while stalled");

	a_s1_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> result_valid)
		else $error("computed item did not reach the result register");

	a_end_not_base: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.block_end |-> result.block_first == '0)
		else $error("block base given on the last element");

	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pos_in.col != IDX_LAST |=> pos_in.col == $past(pos_in.col) + 1'b1)
		else $error("position counter skipped a column");
`endif

endmodule

// ===== hdl/badc_pos.sv =====
// ----------------------------------------------------------------------------
// badc_pos: raster position counter
// Tracks row and column of the next accepted item, wrapping at block end.
// ----------------------------------------------------------------------------
module badc_pos (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	output badc_pkg::pos_t pos
);
	import badc_pkg::*;

	pos_t pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (advance) begin
			if (pos_q.col == IDX_LAST) begin
				pos_q.col <= '0;
				pos_q.row <= (pos_q.row == IDX_LAST) ? '0 : pos_q.row + 1'b1;
			end else begin
				pos_q.col <= pos_q.col + 1'b1;
			end
		end
	end

	assign pos = pos_q;

endmodule

// ===== hdl/badc_row_mem.sv =====
// ----------------------------------------------------------------------------
// badc_row_mem: previous-row sample store
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module badc_row_mem (
	input  logic           clk,
	input  logic           wr_en,
	input  badc_pkg::idx_t wr_addr,
	input  badc_pkg::word_t wr_data,
	input  logic           rd_en,
	input  badc_pkg::idx_t rd_addr,
	output badc_pkg::word_t rd_data
);
	import badc_pkg::*;

	word_t mem [BLOCK_DIM];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// hold the read data while the stage waits
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/badc_dp.sv =====
// ----------------------------------------------------------------------------
// badc_dp: prediction and residual datapath
// Picks the predictor for the position and forms residual or rebuilt sample.
// ----------------------------------------------------------------------------
module badc_dp (
	input  logic                direction,
	input  badc_pkg::pos_t      pos,
	input  badc_pkg::in_item_t  item,
	input  badc_pkg::word_t     left,
	input  badc_pkg::word_t     upper,
	output badc_pkg::out_item_t result,
	output badc_pkg::word_t     sample
);
	import badc_pkg::*;

	logic  at_zero;
	word_t sum;
	word_t pred;
	word_t x;
	word_t base;

	assign x    = word_t'(item.sample);
	assign base = word_t'(item.first_value);

	assign at_zero = (pos.row == '0) && (pos.col == '0);
	assign sum     = left + upper;

	always_comb begin
		if (at_zero) begin
			pred = '0;
		end else if (pos.row == '0) begin
			pred = left;
		end else if (pos.col == '0) begin
			pred = upper;
		end else begin
			// floored average: arithmetic shift of the wrapped sum
			pred = {sum[DATA_W-1], sum[DATA_W-1:1]};
		end
	end

	always_comb begin
		result.block_end = (pos.row == IDX_LAST) && (pos.col == IDX_LAST);
		case (direction)
			DIR_ENCODE: begin
				sample             = x;
				result.value       = at_zero ? '0 : x - pred;
				result.block_first = at_zero ? x : '0;
			end
			DIR_DECODE: begin
				sample             = at_zero ? base : x + pred;
				result.value       = sample;
				result.block_first = '0;
			end
			default: begin
				sample             = x;
				result.value       = '0;
				result.block_first = '0;
			end
		endcase
	end

endmodule

// ===== verif/badc_checker.sv =====
// ----------------------------------------------------------------------------
// badc_checker: result checker for the block average delta codec
// Watches the item, result and register ports. It keeps its own copy of the
// block position, the row store, the left value and the direction. It works
// out each result and compares it field by field with what the codec returns.
// ----------------------------------------------------------------------------
module badc_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic                item_ready,
	input  badc_pkg::in_item_t  item,
	input  logic                result_valid,
	input  logic                result_ready,
	input  badc_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output int                  fail_count,
	output int                  pending_count,
	output int                  checked_count,
	output int                  block_count
);
	import badc_pkg::*;

	word_t     row_above [BLOCK_DIM];
	word_t     left_word;
	idx_t      cur_row;
	idx_t      cur_col;
	logic      dir;
	out_item_t expected_results [$];

	function automatic word_t item_sample(in_item_t it);
		return word_t'(it.sample);
	endfunction

	// Code one item at the current position, then advance the position.
	function automatic out_item_t code_sample(in_item_t it);
		out_item_t o;
		word_t     pred;
		word_t     sum;
		word_t     rebuilt;
		logic      at_origin;
		at_origin = (cur_row == '0) && (cur_col == '0);
		sum       = left_word + row_above[cur_col];
		if (at_origin)
			pred = '0;
		else if (cur_row == '0)
			pred = left_word;
		else if (cur_col == '0)
			pred = row_above[cur_col];
		else
			pred = {sum[DATA_W-1], sum[DATA_W-1:1]};
		o = '0;
		if (dir == DIR_ENCODE) begin
			rebuilt = word_t'(item_sample(it));
			if (at_origin)
				o.block_first = it.sample;
			else
				o.value = rebuilt - pred;
		end else begin
			// the residual is ignored at the block origin; the base is taken
			rebuilt = at_origin ? word_t'(it.first_value) : word_t'(it.sample) + pred;
			o.value = rebuilt;
		end
		o.block_end        = (cur_row == IDX_LAST) && (cur_col == IDX_LAST);
		row_above[cur_col] = rebuilt;
		left_word          = rebuilt;
		if (cur_col == IDX_LAST) begin
			cur_col = '0;
			cur_row = (cur_row == IDX_LAST) ? idx_t'(0) : idx_t'(cur_row + 1'b1);
		end else begin
			cur_col = idx_t'(cur_col + 1'b1);
		end
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t exp_item;
		if (!arst_n) begin
			for (int i = 0; i < BLOCK_DIM; i++)
				row_above[i] = '0;
			left_word     = '0;
			cur_row       = '0;
			cur_col       = '0;
			dir           = DIR_ENCODE;
			fail_count    = 0;
			checked_count = 0;
			block_count   = 0;
			expected_results.delete();
		end else begin
			if (cfg_we)
				dir = cfg_wdata;
			if (item_valid && item_ready)
				expected_results.push_back(code_sample(item));
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with none expected: value %h", result.value);
					fail_count++;
				end else begin
					exp_item = expected_results.pop_front();
					if (result.value !== exp_item.value) begin
						$error("value: expected %h, got %h", exp_item.value, result.value);
						fail_count++;
					end
					if (result.block_first !== exp_item.block_first) begin
						$error("block_first: expected %h, got %h",
							exp_item.block_first, result.block_first);
						fail_count++;
					end
					if (result.block_end !== exp_item.block_end) begin
						$error("block_end: expected %b, got %b",
							exp_item.block_end, result.block_end);
						fail_count++;
					end
					checked_count++;
					if (exp_item.block_end)
						block_count++;
				end
			end
		end
		pending_count = expected_results.size();
	end

endmodule

// ===== verif/tb_block_average_delta_codec_top.sv =====
// ----------------------------------------------------------------------------
// tb_block_average_delta_codec_top: testbench of the block average delta codec
// Drives corner values into part of one block in encode mode. It then
// switches the direction in the middle of the block and runs random phases
// in both directions. Each phase uses its own mix of sender gaps and receiver
// stalls. The checker beside the codec predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_block_average_delta_codec_top;
	import badc_pkg::*;

	localparam int    ITEMS_PER_PHASE = 112;
	localparam word_t CORNER [7] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
		32'hffff_ffff, 32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa};

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;
	logic      cfg_we       = 1'b0;
	logic      cfg_wdata    = 1'b0;

	int fail_count;
	int pending_count;
	int checked_count;
	int block_count;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	block_average_delta_codec_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	badc_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.fail_count   (fail_count),
		.pending_count(pending_count),
		.checked_count(checked_count),
		.block_count  (block_count)
	);

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Corner values often, full random words otherwise.
	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return CORNER[0];
			1: return CORNER[1];
			2: return CORNER[2];
			3: return CORNER[3];
			default: return word_t'($urandom);
		endcase
	endfunction

	// Enter and leave at a falling edge; valid stays high into the next item.
	task automatic send_item(in_item_t it);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	// Hold the sender until every outstanding result has come back.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	task automatic write_direction(logic d);
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin : stimulus
		in_item_t it;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		write_direction(DIR_ENCODE);

		// corner values through the first row, the first column and the interior
		for (int i = 0; i < 25; i++) begin
			it.sample      = CORNER[i % 7];
			it.first_value = CORNER[(i + 3) % 7];
			send_item(it);
		end

		// the first direction change lands in the middle of a block
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
				default: begin send_idle_pct = 26; recv_stall_pct = 26; end
			endcase
			write_direction((ph % 2 == 0) ? DIR_DECODE : DIR_ENCODE);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 2 && n == ITEMS_PER_PHASE / 2)
					drain_results();
				it.sample      = rand_word();
				it.first_value = rand_word();
				send_item(it);
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		$display("Checked %0d results over %0d complete blocks, encode and decode,",
			checked_count, block_count);
		$display("with the direction switched mid-block and four gap/stall mixes.");
		if (fail_count == 0 && pending_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== block_average_delta_codec_top.f =====
hdl/badc_pkg.sv
hdl/badc_pos.sv
hdl/badc_row_mem.sv
hdl/badc_dp.sv
hdl/block_average_delta_codec_top.sv
verif/badc_checker.sv
verif/tb_block_average_delta_codec_top.sv
